@@ hw/rtl/mtg_pkg.sv @@
// Shared types and constants for the bounded uniform random generator.
package mtg_pkg;

	localparam int unsigned TW_N = 624;
	localparam int unsigned TW_M = 397;
	localparam int unsigned TW_AW = 10;
	localparam logic [31:0] TW_MATRIX = 32'h9908_B0DF;
	localparam logic [31:0] TW_UPPER = 32'h8000_0000;
	localparam logic [31:0] TW_LOWER = 32'h7FFF_FFFF;
	localparam logic [31:0] TW_INIT_MUL = 32'd1812433253;
	localparam logic [31:0] SEED_RESET = 32'd5489;

	localparam logic KIND_INT = 1'b0;
	localparam logic KIND_FRAC = 1'b1;

	// request word as classified by the front end
	typedef struct packed {
		logic        kind;
		logic        zero;
		logic [30:0] bound;
	} req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] word;
	} draw_rsp_t;

	typedef struct packed {
		logic        done;
		logic [31:0] rem;
	} div_rsp_t;

endpackage

@@ hw/rtl/bounded_uniform_random_generator_core.sv @@
// Bounded uniform random generator: mt19937 words, Lemire bounded integers, 0.64 fractions.
// Requests enter a two-entry queue and one result word comes out per request, in order.
// After reset and after every seed write the twister table is rebuilt from the seed;
// requests are queued meanwhile and served once that ends. Each twister word takes three
// reads and a write-back on the one-read-port table memory. A fraction takes two words and
// an integer one, plus one per rejected draw and a remainder computation the first time
// the low half of a product falls below the bound.
module bounded_uniform_random_generator_core import mtg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_valid,
	output logic        seed_ready,
	input  logic [31:0] seed_value,
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [30:0] bound,
	output logic        empty,
	input  logic        pop,
	output logic [30:0] number,
	output logic [63:0] fraction
);

	logic      req_valid;
	req_t      req_data;
	logic      req_pop;
	logic      draw_req;
	draw_rsp_t draw_rsp;

	assign seed_ready = 1'b1;

	mtg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.kind     (kind),
		.bound    (bound),
		.req_valid(req_valid),
		.req_data (req_data),
		.req_pop  (req_pop)
	);

	mtg_twister u_twister (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed_valid(seed_valid),
		.seed_value(seed_value),
		.draw_req  (draw_req),
		.draw_rsp  (draw_rsp)
	);

	mtg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_data (req_data),
		.req_pop  (req_pop),
		.draw_req (draw_req),
		.draw_rsp (draw_rsp),
		.empty    (empty),
		.pop      (pop),
		.number   (number),
		.fraction (fraction)
	);

endmodule

@@ hw/rtl/mtg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mtg_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 624
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ hw/rtl/mtg_front.sv @@
// Front end: request intake, classification and a two-entry request queue.
module mtg_front import mtg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [30:0] bound,
	output logic        req_valid,
	output req_t        req_data,
	input  logic        req_pop
);

	req_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full = (cnt_q == 2'd2);
	assign do_push = push && !full;
	assign req_valid = (cnt_q != 2'd0);
	assign do_pop = req_pop && req_valid;
	assign req_data = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q].kind <= kind;
			ent_q[wr_ptr_q].zero <= (kind == KIND_INT) && (bound == 31'd0);
			ent_q[wr_ptr_q].bound <= bound;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			unique case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/mtg_twister.sv @@
// Twister engine: seeding pass and on-demand word generation with tempering.
module mtg_twister import mtg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_valid,
	input  logic [31:0] seed_value,
	input  logic        draw_req,
	output draw_rsp_t   draw_rsp
);

	localparam logic [3:0] T_SEED0 = 4'd0;
	localparam logic [3:0] T_SMUL = 4'd1;
	localparam logic [3:0] T_SWR = 4'd2;
	localparam logic [3:0] T_IDLE = 4'd3;
	localparam logic [3:0] T_RD0 = 4'd4;
	localparam logic [3:0] T_RD1 = 4'd5;
	localparam logic [3:0] T_RD2 = 4'd6;
	localparam logic [3:0] T_GEN = 4'd7;
	localparam logic [3:0] T_TMP = 4'd8;

	localparam logic [TW_AW-1:0] LAST = TW_AW'(TW_N - 1);
	localparam logic [TW_AW-1:0] WRAP_AT = TW_AW'(TW_N - TW_M);

	logic [3:0]       st_q;
	logic [31:0]      seed_q;
	logic [TW_AW-1:0] idx_q;
	logic [TW_AW-1:0] sidx_q;
	logic [31:0]      p_q;
	logic [31:0]      prod_q;
	logic [31:0]      a_q;
	logic [31:0]      b_q;
	logic [31:0]      y_q;

	logic             wr_en;
	logic [TW_AW-1:0] wr_addr;
	logic [31:0]      wr_data;
	logic [TW_AW-1:0] rd_addr;
	logic [31:0]      rd_data;
	logic [TW_AW-1:0] idx_next;
	logic [TW_AW-1:0] idx_far;
	logic [31:0]      seed_word;
	logic [31:0]      mix;
	logic [31:0]      gen_word;
	logic [31:0]      t0, t1, t2, t3;

	mtg_ram #(.WIDTH(32), .DEPTH(TW_N)) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign idx_next = (idx_q == LAST) ? '0 : idx_q + 1'b1;
	assign idx_far = (idx_q >= WRAP_AT) ? idx_q - WRAP_AT : idx_q + TW_AW'(TW_M);
	assign seed_word = prod_q + {{(32 - TW_AW){1'b0}}, sidx_q};
	assign mix = (a_q & TW_UPPER) | (b_q & TW_LOWER);
	// entries above the current index still hold the previous generation
	assign gen_word = rd_data ^ (mix >> 1) ^ (mix[0] ? TW_MATRIX : 32'd0);

	assign t0 = y_q ^ (y_q >> 11);
	assign t1 = t0 ^ ((t0 << 7) & 32'h9D2C_5680);
	assign t2 = t1 ^ ((t1 << 15) & 32'hEFC6_0000);
	assign t3 = t2 ^ (t2 >> 18);

	assign draw_rsp.done = (st_q == T_TMP);
	assign draw_rsp.word = t3;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = idx_q;
		wr_data = gen_word;
		rd_addr = idx_q;
		unique case (st_q)
			T_SEED0: begin
				wr_en = 1'b1;
				wr_addr = '0;
				wr_data = seed_q;
			end
			T_SWR: begin
				wr_en = 1'b1;
				wr_addr = sidx_q;
				wr_data = seed_word;
			end
			T_RD1: rd_addr = idx_next;
			T_RD2: rd_addr = idx_far;
			T_GEN: wr_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			T_SEED0: p_q <= seed_q;
			T_SMUL: prod_q <= TW_INIT_MUL * (p_q ^ (p_q >> 30));
			T_SWR: p_q <= seed_word;
			T_RD1: a_q <= rd_data;
			T_RD2: b_q <= rd_data;
			T_GEN: y_q <= gen_word;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= T_SEED0;
			seed_q <= SEED_RESET;
			idx_q <= '0;
			sidx_q <= '0;
		end else if (seed_valid) begin
			seed_q <= seed_value;
			st_q <= T_SEED0;
		end else begin
			unique case (st_q)
				T_SEED0: begin
					idx_q <= '0;
					sidx_q <= TW_AW'(1);
					st_q <= T_SMUL;
				end
				T_SMUL: st_q <= T_SWR;
				T_SWR: begin
					if (sidx_q == LAST) begin
						st_q <= T_IDLE;
					end else begin
						sidx_q <= sidx_q + 1'b1;
						st_q <= T_SMUL;
					end
				end
				T_IDLE: if (draw_req) st_q <= T_RD0;
				T_RD0: st_q <= T_RD1;
				T_RD1: st_q <= T_RD2;
				T_RD2: st_q <= T_GEN;
				T_GEN: begin
					idx_q <= idx_next;
					st_q <= T_TMP;
				end
				T_TMP: st_q <= T_IDLE;
				default: st_q <= T_SEED0;
			endcase
		end
	end

endmodule

@@ hw/rtl/mtg_divider.sv @@
// Restoring divider, one quotient bit per cycle; returns the remainder only.
module mtg_divider import mtg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [30:0] divisor,
	output div_rsp_t    rsp
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [31:0] dvd_q;
	logic [31:0] rem_q;
	logic [31:0] trial;
	logic [31:0] rem_next;

	assign trial = {rem_q[30:0], dvd_q[31]};
	assign rem_next = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;

	assign rsp.done = busy_q && (cnt_q == 6'd32);
	assign rsp.rem = rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q && cnt_q != 6'd32) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == 6'd32) busy_q <= 1'b0;
			else cnt_q <= cnt_q + 6'd1;
		end
	end

endmodule

@@ hw/rtl/mtg_back.sv @@
// Back end: runs requests against the twister, Lemire rejection, result register.
module mtg_back import mtg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  req_t        req_data,
	output logic        req_pop,
	output logic        draw_req,
	input  draw_rsp_t   draw_rsp,
	output logic        empty,
	input  logic        pop,
	output logic [30:0] number,
	output logic [63:0] fraction
);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_LO = 3'd1;
	localparam logic [2:0] B_HI = 3'd2;
	localparam logic [2:0] B_INT = 3'd3;
	localparam logic [2:0] B_MUL = 3'd4;
	localparam logic [2:0] B_CHK = 3'd5;
	localparam logic [2:0] B_DIV = 3'd6;
	localparam logic [2:0] B_OUT = 3'd7;

	logic [2:0]  st_q;
	req_t        cur_q;
	logic [31:0] word_q;
	logic [31:0] lo_q;
	logic [62:0] prod_q;
	logic [31:0] thr_q;
	logic        thr_ok_q;
	logic [30:0] res_num_q;
	logic [63:0] res_frac_q;
	logic        out_valid_q;
	logic        div_start;
	div_rsp_t    div_rsp;
	logic        low_small;

	mtg_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(32'd0 - {1'b0, cur_q.bound}),
		.divisor (cur_q.bound),
		.rsp     (div_rsp)
	);

	assign low_small = prod_q[31:0] < {1'b0, cur_q.bound};
	assign req_pop = (st_q == B_IDLE) && req_valid;
	assign draw_req = (st_q == B_LO) || (st_q == B_HI) || (st_q == B_INT);
	assign div_start = (st_q == B_CHK) && low_small && !thr_ok_q;
	assign empty = !out_valid_q;

	always_ff @(posedge clk) begin
		unique case (st_q)
			B_IDLE: begin
				cur_q <= req_data;
				res_num_q <= '0;
				res_frac_q <= '0;
			end
			B_LO: if (draw_rsp.done) lo_q <= draw_rsp.word;
			B_HI: if (draw_rsp.done) res_frac_q <= {draw_rsp.word, lo_q};
			B_INT: if (draw_rsp.done) word_q <= draw_rsp.word;
			B_MUL: prod_q <= {31'd0, word_q} * {32'd0, cur_q.bound};
			B_CHK: res_num_q <= prod_q[62:32];
			B_DIV: if (div_rsp.done) thr_q <= div_rsp.rem;
			B_OUT: begin
				if (!out_valid_q) begin
					number <= res_num_q;
					fraction <= res_frac_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			thr_ok_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && out_valid_q) out_valid_q <= 1'b0;
			unique case (st_q)
				B_IDLE: begin
					thr_ok_q <= 1'b0;
					if (req_valid) begin
						priority if (req_data.zero) st_q <= B_OUT;
						else if (req_data.kind == KIND_FRAC) st_q <= B_LO;
						else st_q <= B_INT;
					end
				end
				B_LO: if (draw_rsp.done) st_q <= B_HI;
				B_HI: if (draw_rsp.done) st_q <= B_OUT;
				B_INT: if (draw_rsp.done) st_q <= B_MUL;
				B_MUL: st_q <= B_CHK;
				B_CHK: begin
					// threshold (2^32 - bound) mod bound is needed only once per request
					priority if (!low_small) st_q <= B_OUT;
					else if (!thr_ok_q) st_q <= B_DIV;
					else if (prod_q[31:0] < thr_q) st_q <= B_INT;
					else st_q <= B_OUT;
				end
				B_DIV: begin
					if (div_rsp.done) begin
						thr_ok_q <= 1'b1;
						st_q <= B_CHK;
					end
				end
				B_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						st_q <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

endmodule
